[rtl/fw_pkg.sv]
// shared widths, codes and command type for the binary indexed tree block
package fw_pkg;

  // field widths
  localparam int POS_W       = 10;
  localparam int DELTA_W     = 32;
  localparam int SUM_W       = 64;
  localparam int SIZE_W      = 11;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 64;

  // defaults
  localparam int                DEPTH_DEFAULT = 1024;
  localparam logic [SIZE_W-1:0] SIZE_RESET    = 11'd1024;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // operation codes carried on tuser
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // classified command handed from front to back
  typedef struct packed {
    logic               is_query;
    logic               skip;
    logic [DELTA_W-1:0] delta;
  } fw_cmd_t;

endpackage

[rtl/fw_ram.sv]
// generic simple dual port ram with registered read
module fw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/fw_front.sv]
// front end: size register, transaction intake, classification and command queue
module fw_front import fw_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       busy,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [IN_TDATA_W-1:0]      in_tdata,
  input  logic                       in_tuser,
  input  logic                       cfg_wr_en,
  input  logic [SIZE_W-1:0]          cfg_wr_data,
  output logic                       cmd_valid,
  input  logic                       cmd_ready,
  output fw_cmd_t                    cmd,
  output logic [$clog2(DEPTH)+1:0]   cmd_node,
  output logic [$clog2(DEPTH)+1:0]   limit
);

  localparam int NW = $clog2(DEPTH) + 2;

  logic [SIZE_W-1:0]   size_r;
  logic [POS_W-1:0]    pos;
  logic [POS_W:0]      start;
  logic [31:0]         limit_full;
  logic                is_query;
  fw_cmd_t             new_cmd;
  logic [NW-1:0]       new_node;

  fw_cmd_t             q_cmd_r  [QUEUE_DEPTH];
  logic [NW-1:0]       q_node_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_AW:0]   cnt_r;
  logic                push;
  logic                pop;

  // size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_wr_en) begin
      size_r <= cfg_wr_data;
    end
  end

  // effective size, clamped to the store depth
  assign limit_full = (32'(size_r) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(size_r);
  assign limit      = NW'(limit_full);

  // classify the incoming transaction
  assign pos      = in_tdata[POS_W-1:0];
  assign start    = {1'b0, pos} + (POS_W+1)'(1);
  assign is_query = (in_tuser == FUNC_QUERY);

  always_comb begin
    new_cmd.is_query = is_query;
    new_cmd.delta    = in_tdata[POS_W +: DELTA_W];
    // an add whose start node lies past the size in use changes nothing
    new_cmd.skip     = !is_query && (32'(start) > limit_full);
    // queries beyond the store start at its top node
    if (32'(start) > 32'(DEPTH)) begin
      new_node = NW'(DEPTH);
    end else begin
      new_node = NW'(start);
    end
  end

  // command queue
  assign in_tready = !busy && (cnt_r != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (cnt_r != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_cmd_r[rd_ptr_r];
  assign cmd_node  = q_node_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        q_cmd_r[wr_ptr_r]  <= new_cmd;
        q_node_r[wr_ptr_r] <= new_node;
        wr_ptr_r           <= wr_ptr_r + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (QUEUE_AW+1)'(1);
      end
    end
  end

endmodule

[rtl/fw_back.sv]
// back end: clearing pass, tree walks over the partial sum memory, result register
module fw_back import fw_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  output logic                     busy,
  input  logic                     cmd_valid,
  output logic                     cmd_ready,
  input  fw_cmd_t                  cmd,
  input  logic [$clog2(DEPTH)+1:0] cmd_node,
  input  logic [$clog2(DEPTH)+1:0] limit,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_TDATA_W-1:0]   out_tdata
);

  localparam int NW = $clog2(DEPTH) + 2;
  localparam int AW = $clog2(DEPTH);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_WALK, ST_DRAIN} state_t;

  state_t             state_r;
  logic [AW-1:0]      clr_cnt_r;
  logic [NW-1:0]      node_r;
  logic [DELTA_W-1:0] delta_r;
  logic               is_query_r;
  logic [SUM_W-1:0]   acc_r;
  logic               p_valid_r;
  logic [AW-1:0]      p_addr_r;
  logic               out_tvalid_r;
  logic [SUM_W-1:0]   out_tdata_r;

  logic [NW-1:0]      lowbit;
  logic [NW-1:0]      node_up;
  logic [NW-1:0]      node_dn;
  logic [NW-1:0]      node_m1;
  logic [AW-1:0]      node_addr;
  logic               walk_more;
  logic [DELTA_W-1:0] rdata;
  logic [SUM_W-1:0]   acc_sum;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [DELTA_W-1:0] ram_wdata;

  // node stepping
  assign lowbit    = node_r & (~node_r + NW'(1));
  assign node_up   = node_r + lowbit;
  assign node_dn   = node_r - lowbit;
  assign node_m1   = node_r - NW'(1);
  assign node_addr = node_m1[AW-1:0];
  assign walk_more = is_query_r ? (node_dn != '0) : (node_up <= limit);

  // accumulate the entry read back, sign extended
  assign acc_sum = acc_r + {{(SUM_W-DELTA_W){rdata[DELTA_W-1]}}, rdata};

  // memory write: zeros during the clearing pass, updated entry during an add
  assign ram_we    = (state_r == ST_CLEAR) || (p_valid_r && !is_query_r);
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : p_addr_r;
  assign ram_wdata = (state_r == ST_CLEAR) ? '0 : (rdata + delta_r);

  fw_ram #(
    .WIDTH (DELTA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (node_addr),
    .rdata (rdata)
  );

  // a query waits until the result register is free or being freed
  assign cmd_ready  = (state_r == ST_IDLE) &&
                      (!cmd.is_query || !out_tvalid_r || out_tready);
  assign busy       = (state_r == ST_CLEAR);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // sequencer, read pipeline and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      p_valid_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      p_valid_r <= (state_r == ST_WALK);
      if (p_valid_r && is_query_r) begin
        acc_r <= acc_sum;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
          if (clr_cnt_r == AW'(DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_valid && cmd_ready && !cmd.skip) begin
            node_r     <= cmd_node;
            delta_r    <= cmd.delta;
            is_query_r <= cmd.is_query;
            acc_r      <= '0;
            state_r    <= ST_WALK;
          end
        end
        ST_WALK: begin
          p_addr_r  <= node_addr;
          node_r    <= is_query_r ? node_dn : node_up;
          if (!walk_more) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (is_query_r) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= acc_sum;
          end
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/fenwick_tree_point_add_prefix_sum.sv]
// Binary indexed tree of DEPTH signed 32-bit partial sums with point add and
// prefix-sum query. After reset a clearing pass zeroes the store, one entry per
// cycle, during which in_tready stays low; the size register can still be
// written. Transactions go into a two-entry command queue, so intake goes on
// while a walk runs or a result waits on the output. A walk reads one node per
// cycle through the single read port of the store; an add whose position lies
// past the size in use does not walk the tree. A query returns one 64-bit
// result, an add none.
module fenwick_tree_point_add_prefix_sum import fw_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input transactions
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // position[9:0], delta[41:10], zero[47:42]
  input  logic                   in_tuser,   // func[0]: 0 add, 1 query
  // result transactions
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // prefix_total[63:0]
  // size register write
  input  logic                   cfg_wr_en,
  input  logic [SIZE_W-1:0]      cfg_wr_data
);

  localparam int NW = $clog2(DEPTH) + 2;

  logic          busy;
  logic          cmd_valid;
  logic          cmd_ready;
  fw_cmd_t       cmd;
  logic [NW-1:0] cmd_node;
  logic [NW-1:0] limit;

  // intake and classification
  fw_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .busy        (busy),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .cmd_node    (cmd_node),
    .limit       (limit)
  );

  // tree walker
  fw_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .busy       (busy),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .cmd_node   (cmd_node),
    .limit      (limit),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[rtl/fw_checker.sv]
// port level checks for the binary indexed tree block, bound to the top level
module fw_checker import fw_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // reset empties the result register and starts the clearing pass
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("result pending or intake open right after reset");

  // intake stays closed right after reset is released, while the clearing pass runs
  a_clear_pass: assert property (@(posedge clk)
    !rst_n ##1 rst_n ##1 rst_n |-> !in_tready)
    else $error("intake opened before the store was cleared");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

endmodule

bind fenwick_tree_point_add_prefix_sum fw_checker u_fw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[test/tb_top.sv]
// testbench for the binary indexed tree block: point adds and prefix-sum queries
module tb_top;
  import fw_pkg::*;

  localparam int TREE_DEPTH    = DEPTH_DEFAULT;
  localparam int SETTLE_CYCLES = 60;   // covers the queue and the longest walk
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 125;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;  // position[9:0], delta[41:10], zero[47:42]
  logic                   in_tuser    = FUNC_ADD;  // func[0]
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;   // prefix_total[63:0]
  logic                   cfg_wr_en   = 1'b0;
  logic [SIZE_W-1:0]      cfg_wr_data = '0;

  // shadow copy of the tree and the size register
  logic [DELTA_W-1:0] tree_nodes [TREE_DEPTH];
  logic [SIZE_W-1:0]  size_shadow;
  logic [SUM_W-1:0]   expected_sums [$];

  int  errors          = 0;
  int  items_sent      = 0;
  int  results_checked = 0;
  int  cfg_writes      = 0;
  bit  no_idle         = 1'b0;
  int  rx_wait         = 0;
  logic hold_req       = 1'b0;
  logic hold_seen      = 1'b0;
  int  hold_left       = 0;

  fenwick_tree_point_add_prefix_sum #(.DEPTH(TREE_DEPTH)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // overall time limit
  initial begin
    #5_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // idle cycles for the next transaction on either side
  function automatic int draw_wait();
    if (no_idle) return 0;
    return $urandom_range(0, 19);
  endfunction

  // walk the shadow tree: add updates nodes, query pushes the expected sum
  task automatic predict_tree_op(input logic func, input logic [POS_W-1:0] pos,
                                 input logic [DELTA_W-1:0] delta);
    int unsigned node;
    int unsigned limit;
    logic [SUM_W-1:0] total;
    node = pos + 1;
    if (func == FUNC_ADD) begin
      limit = (size_shadow > TREE_DEPTH) ? TREE_DEPTH : size_shadow;
      while (node >= 1 && node <= limit) begin
        tree_nodes[node-1] = tree_nodes[node-1] + delta;
        node = node + (node & (~node + 1));
      end
    end else begin
      total = '0;
      if (node > TREE_DEPTH) node = TREE_DEPTH;
      while (node > 0) begin
        total = total + {{(SUM_W-DELTA_W){tree_nodes[node-1][DELTA_W-1]}}, tree_nodes[node-1]};
        node = node - (node & (~node + 1));
      end
      expected_sums.push_back(total);
    end
  endtask

  // offer one transaction; valid stays high until the next call or settle
  task automatic send_item(input logic func, input logic [POS_W-1:0] pos,
                           input logic [DELTA_W-1:0] delta);
    int gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {{(IN_TDATA_W-POS_W-DELTA_W){1'b0}}, delta, pos};
    do @(posedge clk); while (!in_tready);
    predict_tree_op(func, pos, delta);
    items_sent++;
  endtask

  // stop offering, wait for all sums, then let trailing adds finish
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // size register write, only while the block is idle
  task automatic write_size(input logic [SIZE_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    size_shadow = value;
    cfg_writes++;
    @(posedge clk);
  endtask

  function automatic logic [DELTA_W-1:0] rand_delta();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 16) - 8;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // mostly inside the size in use, sometimes anywhere
  function automatic logic [POS_W-1:0] rand_pos(input int eff);
    if (eff > 0 && $urandom_range(0, 99) < 85) return POS_W'($urandom_range(0, eff - 1));
    return POS_W'($urandom_range(0, TREE_DEPTH - 1));
  endfunction

  // long output hold-off, counted here
  always @(posedge clk) begin
    hold_seen <= hold_req;
    if (hold_req != hold_seen) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // result side: check each sum against the oldest expectation, then pace ready
  always @(posedge clk) begin
    logic [SUM_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_sums.size() == 0) begin
        $error("unexpected result: prefix_total actual %0d", $signed(out_tdata));
        errors++;
      end else begin
        want = expected_sums.pop_front();
        if (out_tdata !== want) begin
          $error("prefix_total mismatch: expected %0d, actual %0d",
                 $signed(want), $signed(out_tdata));
          errors++;
        end
        results_checked++;
      end
      rx_wait = draw_wait();
    end
    if (hold_left != 0) out_tready <= 1'b0;
    else if (rx_wait != 0) begin
      rx_wait--;
      out_tready <= 1'b0;
    end else out_tready <= 1'b1;
  end

  // empty tree, extreme deltas and positions, entry wraparound
  task automatic test_directed_basic();
    send_item(FUNC_QUERY, 10'd0,    32'h0);
    send_item(FUNC_QUERY, 10'd1023, 32'hFFFF_FFFF);
    send_item(FUNC_ADD,   10'd0,    32'h7FFF_FFFF);
    send_item(FUNC_ADD,   10'd1023, 32'h8000_0000);
    send_item(FUNC_ADD,   10'd511,  32'h7FFF_FFFF);
    send_item(FUNC_ADD,   10'd511,  32'h7FFF_FFFF);
    send_item(FUNC_ADD,   10'd0,    32'hFFFF_FFFF);
    send_item(FUNC_QUERY, 10'd0,    32'h0);
    send_item(FUNC_QUERY, 10'd510,  32'h0);
    send_item(FUNC_QUERY, 10'd511,  32'h0);
    send_item(FUNC_QUERY, 10'd1023, 32'h0);
    settle();
  endtask

  // size zero, size above depth, adds and queries beyond the size
  task automatic test_size_special_cases();
    write_size(11'd0);
    send_item(FUNC_ADD,   10'd5,    32'd100);
    send_item(FUNC_QUERY, 10'd1023, 32'h0);
    settle();
    write_size(11'd2047);
    send_item(FUNC_ADD,   10'd1023, 32'd1);
    send_item(FUNC_ADD,   10'd0,    -32'sd5);
    send_item(FUNC_QUERY, 10'd1023, 32'h0);
    send_item(FUNC_QUERY, 10'd0,    32'h0);
    settle();
    write_size(11'd3);
    send_item(FUNC_ADD,   10'd3,    32'd1000);
    send_item(FUNC_ADD,   10'd2,    32'd7);
    send_item(FUNC_ADD,   10'd0,    32'd3);
    send_item(FUNC_QUERY, 10'd3,    32'h0);
    send_item(FUNC_QUERY, 10'd2,    32'h0);
    send_item(FUNC_QUERY, 10'd1023, 32'h0);
    settle();
  endtask

  // random mix of adds and queries over several size settings
  task automatic test_random_sizes();
    int sizes [11];
    int eff;
    logic func;
    sizes = '{1, 2, 1024, 2047, 0, 37, 513, 1023, 0, 0, 0};
    for (int p = 0; p < 11; p++) begin
      if (p >= 8) sizes[p] = $urandom_range(0, 2047);
      write_size(SIZE_W'(sizes[p]));
      eff = (sizes[p] > TREE_DEPTH) ? TREE_DEPTH : sizes[p];
      no_idle = (p == 3 || p == 7);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        func = ($urandom_range(0, 99) < 55) ? FUNC_ADD : FUNC_QUERY;
        send_item(func, rand_pos(eff), rand_delta());
      end
      settle();
    end
    no_idle = 1'b0;
  endtask

  // output held off while the sender keeps offering, so intake stalls
  task automatic test_backpressure();
    logic func;
    write_size(11'd1024);
    no_idle = 1'b1;
    hold_req <= ~hold_req;
    for (int i = 0; i < 30; i++) begin
      func = ($urandom_range(0, 2) != 0) ? FUNC_QUERY : FUNC_ADD;
      send_item(func, rand_pos(TREE_DEPTH), rand_delta());
    end
    no_idle = 1'b0;
    settle();
  endtask

  // test sequence
  initial begin
    foreach (tree_nodes[i]) tree_nodes[i] = '0;
    size_shadow = SIZE_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_basic();
    test_size_special_cases();
    test_random_sizes();
    test_backpressure();
    if (expected_sums.size() != 0) begin
      $error("%0d expected prefix sums never arrived", expected_sums.size());
      errors++;
    end
    $display("run covered %0d transactions, %0d prefix sums checked, %0d size writes",
             items_sent, results_checked, cfg_writes);
    $display("including size zero, size above depth and a long output stall");
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/fw_pkg.sv
rtl/fw_ram.sv
rtl/fw_front.sv
rtl/fw_back.sv
rtl/fenwick_tree_point_add_prefix_sum.sv
rtl/fw_checker.sv
test/tb_top.sv
